// ----- hw/rtl/sbfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbfd_pkg: shared constants and types for the frame channel decoder
// Frame geometry, marker bytes and the frame beat passed to the queue.
// ----------------------------------------------------------------------------
package sbfd_pkg;

    // frame geometry
    localparam int FRAME_LEN    = 25;
    localparam int PAYLOAD_LEN  = 22;
    localparam int BYTE_W       = 8;
    localparam int PAYLOAD_W    = PAYLOAD_LEN * BYTE_W;
    localparam int POS_W        = 5;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_W       = 11;
    localparam int CHAN_IDX_W   = 4;

    // positions inside a frame
    localparam logic [POS_W-1:0] POS_HEADER    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_PAY_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PAY_LAST  = POS_W'(PAYLOAD_LEN);
    localparam logic [POS_W-1:0] POS_END       = POS_W'(FRAME_LEN - 1);

    // marker bytes
    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;
    localparam logic [BYTE_W-1:0] END_BYTE    = 8'h00;

    // last channel of a frame
    localparam logic [CHAN_IDX_W-1:0] LAST_CHAN = CHAN_IDX_W'(NUM_CHANNELS - 1);

    // frame queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // one complete frame handed from the front end to the queue
    typedef struct packed {
        logic                 push;
        logic [PAYLOAD_W-1:0] payload;
    } frame_beat_t;

    // queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sbfd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbfd_front: byte framing front end
// Counts byte position modulo 25, checks header and end bytes, collects the
// 22 payload bytes and pushes a complete good frame into the queue.
// ----------------------------------------------------------------------------
module sbfd_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rx_valid,
    output logic                              rx_stall,
    input  wire logic [sbfd_pkg::BYTE_W-1:0]  rx_byte,
    input  wire sbfd_pkg::queue_stat_t        q_stat,
    output sbfd_pkg::frame_beat_t             frame_beat
);

    logic [sbfd_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                           hdr_ok_reg, hdr_ok_next;
    logic [sbfd_pkg::PAYLOAD_W-1:0] store_reg, store_next;
    logic                           accept;
    logic                           is_payload;
    logic                           is_end;

    // only the end byte may need queue space
    assign is_end   = (pos_reg == sbfd_pkg::POS_END);
    assign rx_stall = is_end && q_stat.full;
    assign accept   = rx_valid && !rx_stall;

    // position classification and next state
    always_comb
    begin
        is_payload  = pos_reg inside {[sbfd_pkg::POS_PAY_FIRST:sbfd_pkg::POS_PAY_LAST]};
        pos_next    = pos_reg;
        hdr_ok_next = hdr_ok_reg;
        store_next  = store_reg;
        if (accept)
        begin
            pos_next = is_end ? sbfd_pkg::POS_HEADER : pos_reg + 1'b1;
            if (pos_reg == sbfd_pkg::POS_HEADER)
            begin
                hdr_ok_next = (rx_byte == sbfd_pkg::HEADER_BYTE);
            end
            // payload shifts in from the top: first byte ends at bits [7:0]
            if (is_payload)
            begin
                store_next = {rx_byte, store_reg[sbfd_pkg::PAYLOAD_W-1:sbfd_pkg::BYTE_W]};
            end
        end
    end

    // push a good frame
    always_comb
    begin
        frame_beat.push    = accept && is_end && hdr_ok_reg
                             && (rx_byte == sbfd_pkg::END_BYTE);
        frame_beat.payload = store_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= sbfd_pkg::POS_HEADER;
            hdr_ok_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
        end
    end

    // payload collection
    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sbfd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbfd_queue: two-entry frame queue
// Holds complete frames between the front end and the channel unpacker.
// ----------------------------------------------------------------------------
module sbfd_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sbfd_pkg::frame_beat_t         frame_beat,
    input  wire logic                          pop,
    output sbfd_pkg::queue_stat_t              q_stat,
    output logic [sbfd_pkg::PAYLOAD_W-1:0]     head
);

    logic [sbfd_pkg::PAYLOAD_W-1:0]   entry_reg [sbfd_pkg::QUEUE_DEPTH];
    logic [sbfd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sbfd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sbfd_pkg::QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                             do_push;
    logic                             do_pop;

    // status
    always_comb
    begin
        q_stat.full  = (cnt_reg == sbfd_pkg::QUEUE_CNT_W'(sbfd_pkg::QUEUE_DEPTH));
        q_stat.empty = (cnt_reg == '0);
    end

    assign do_push = frame_beat.push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;
    assign head    = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // frame storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= frame_beat.payload;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sbfd_unpack.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbfd_unpack: channel unpacker back end
// Takes a frame from the queue and shifts out sixteen 11-bit channels,
// one beat per cycle unless ch_stall holds it, through a registered output stage.
// ----------------------------------------------------------------------------
module sbfd_unpack (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sbfd_pkg::queue_stat_t             q_stat,
    input  wire logic [sbfd_pkg::PAYLOAD_W-1:0]    head,
    output logic                                   pop,
    output logic                                   ch_valid,
    input  wire logic                              ch_stall,
    output logic [sbfd_pkg::CHAN_IDX_W-1:0]        channel_index,
    output logic [sbfd_pkg::CHAN_W-1:0]            channel_value,
    output logic                                   last_channel
);

    logic                            busy_reg, busy_next;
    logic [sbfd_pkg::CHAN_IDX_W-1:0] k_reg, k_next;
    logic [sbfd_pkg::PAYLOAD_W-1:0]  frame_reg, frame_next;
    logic                            vld_reg, vld_next;
    logic [sbfd_pkg::CHAN_IDX_W-1:0] idx_reg, idx_next;
    logic [sbfd_pkg::CHAN_W-1:0]     val_reg, val_next;
    logic                            last_reg, last_next;
    logic                            advance;

    assign pop     = !busy_reg && !q_stat.empty;
    assign advance = busy_reg && (!vld_reg || !ch_stall);

    // channel sequencing
    always_comb
    begin
        busy_next  = busy_reg;
        k_next     = k_reg;
        frame_next = frame_reg;
        vld_next   = vld_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        if (pop)
        begin
            busy_next  = 1'b1;
            k_next     = '0;
            frame_next = head;
        end
        if (advance)
        begin
            vld_next   = 1'b1;
            idx_next   = k_reg;
            val_next   = frame_reg[sbfd_pkg::CHAN_W-1:0];
            last_next  = (k_reg == sbfd_pkg::LAST_CHAN);
            frame_next = frame_reg >> sbfd_pkg::CHAN_W;
            k_next     = k_reg + 1'b1;
            if (k_reg == sbfd_pkg::LAST_CHAN)
            begin
                busy_next = 1'b0;
            end
        end
        else if (vld_reg && !ch_stall)
        begin
            vld_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
            vld_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
            vld_reg  <= vld_next;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        last_reg  <= last_next;
    end

    assign ch_valid      = vld_reg;
    assign channel_index = idx_reg;
    assign channel_value = val_reg;
    assign last_channel  = last_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/sbus_frame_channel_decoder.sv -----
// A good end byte's frame enters the decoupling two-frame queue; the unpacker
// loads it and registers channel 0. Throughput: one byte per cycle in; sixteen
// beats per frame out, one per cycle when not stalled, set by the unpacker.
// The input stalls only on an end byte while the frame queue is full.
// Reset (rst_n, async): position, header flag, queue and output valid cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_frame_channel_decoder: 25-byte frame to 16-channel decoder
// Front end frames bytes, a queue holds good frames, the back end unpacks.
// ----------------------------------------------------------------------------
module sbus_frame_channel_decoder (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             rx_valid,
    output logic                                  rx_stall,
    input  wire logic [sbfd_pkg::BYTE_W-1:0]      rx_byte,
    output logic                                  ch_valid,
    input  wire logic                             ch_stall,
    output logic [sbfd_pkg::CHAN_IDX_W-1:0]       channel_index,
    output logic [sbfd_pkg::CHAN_W-1:0]           channel_value,
    output logic                                  last_channel
);

    sbfd_pkg::frame_beat_t          frame_beat;
    sbfd_pkg::queue_stat_t          q_stat;
    logic [sbfd_pkg::PAYLOAD_W-1:0] head;
    logic                           pop;

    // framing front end
    sbfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .q_stat     (q_stat),
        .frame_beat (frame_beat)
    );

    // frame queue
    sbfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_beat (frame_beat),
        .pop        (pop),
        .q_stat     (q_stat),
        .head       (head)
    );

    // channel unpacker
    sbfd_unpack u_unpack (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .head          (head),
        .pop           (pop),
        .ch_valid      (ch_valid),
        .ch_stall      (ch_stall),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last_channel  (last_channel)
    );

endmodule
`default_nettype wire
